// ----- hw/rtl/lwt_pkg.sv -----
// lwt_pkg: shared types and constants for the lock with waiter table
// request, status and config index codes, sequencer states, field widths
// no dependencies
package lwt_pkg;

	localparam int TASK_W    = 8;
	localparam int PID_W     = 16;
	localparam int COUNT_W   = 31;
	localparam int STATUS_W  = 3;
	localparam int REQ_W     = 2;
	localparam int CFG_IDX_W = 1;
	localparam int ENTRY_W   = TASK_W + PID_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [REQ_W-1:0] {
		REQ_WAIT = 2'd0,
		REQ_TRY  = 2'd1,
		REQ_POST = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_GRANTED     = 3'd0,
		STS_QUEUED      = 3'd1,
		STS_FULL        = 3'd2,
		STS_WOULD_BLOCK = 3'd3,
		STS_OVERFLOW    = 3'd4,
		STS_NOT_LOCKED  = 3'd5,
		STS_WAKE        = 3'd6
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAST_CHK,
		S_ENTER,
		S_REMOVE,
		S_RELEASE,
		S_FINISH
	} state_t;

endpackage

// ----- hw/rtl/lwt_ram.sv -----
// lwt_ram: generic single write port, single read port ram with registered read
// used for the waiter table entries; no package dependency
module lwt_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/lock_with_waiter_table.sv -----
// lock_with_waiter_table: counting semaphore or mutex with a table of waiting tasks
// depends on lwt_pkg and lwt_ram (waiter entries)
//
// A request is taken when start is high and busy is low; results come out one per
// cycle on the status, wake_task, wake_pid and last_result ports, each marked by
// result_valid for one cycle, and cannot be stalled. Try-wait, overflow, not-locked
// and immediate grant or queue-full answers come straight from the idle state. A blocking
// wait that queues reads the last used slot and then checks one slot per cycle for a free one;
// a granted wait that removes the task's entry and a post or unlock both scan the table
// one slot per cycle through the single read port of the waiter ram; a post or unlock
// emits a wake result for each occupied slot found, a mutex unlock only for the first.
// Config writes are always ready and clear the table at once.
module lock_with_waiter_table #(
	parameter int WAIT_SLOTS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [lwt_pkg::REQ_W-1:0]      req_type,
	input  logic [lwt_pkg::TASK_W-1:0]     task_id,
	input  logic [lwt_pkg::PID_W-1:0]      task_pid,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lwt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lwt_pkg::COUNT_W-1:0]    cfg_data,
	output logic                           result_valid,
	output logic [lwt_pkg::STATUS_W-1:0]   status,
	output logic [lwt_pkg::TASK_W-1:0]     wake_task,
	output logic [lwt_pkg::PID_W-1:0]      wake_pid,
	output logic                           last_result
);

	localparam int SLOT_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
	localparam int POS_W  = $clog2(WAIT_SLOTS + 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WAIT_SLOTS - 1);
	localparam logic [POS_W-1:0]  POS_ALL   = POS_W'(WAIT_SLOTS);
	localparam logic [POS_W-1:0]  POS_LESS  = POS_W'(WAIT_SLOTS - 1);

	// configuration and lock state
	logic                          mode_q;
	logic [lwt_pkg::COUNT_W-1:0]   init_q;
	logic [lwt_pkg::COUNT_W-1:0]   count_q;
	logic [WAIT_SLOTS-1:0]         occ_q;
	logic [SLOT_W-1:0]             last_q;
	logic                          last_vld_q;

	// sequencer
	lwt_pkg::state_t               state_q, state_d;
	logic [lwt_pkg::TASK_W-1:0]    task_q;
	logic [lwt_pkg::PID_W-1:0]     pid_q;
	logic                          first_q;
	logic [SLOT_W-1:0]             slot_q;
	logic [POS_W-1:0]              pos_q;
	logic [POS_W-1:0]              lim_q;
	logic                          vld_s1;
	logic [SLOT_W-1:0]             slot_s1;

	// result register
	logic                          res_vld_q;
	logic [lwt_pkg::STATUS_W-1:0]  status_q;
	logic [lwt_pkg::TASK_W-1:0]    wtask_q;
	logic [lwt_pkg::PID_W-1:0]     wpid_q;
	logic                          last_res_q;

	// ram
	logic                          ram_we;
	logic [SLOT_W-1:0]             ram_raddr;
	logic [lwt_pkg::ENTRY_W-1:0]   ram_rdata;
	logic [lwt_pkg::TASK_W-1:0]    rd_task;
	logic [lwt_pkg::PID_W-1:0]     rd_pid;

	// combinational controls
	logic                          accept;
	logic                          cfg_we;
	lwt_pkg::req_t                 req;
	logic                          count_zero;
	logic                          count_full;
	logic [SLOT_W-1:0]             slot_inc;
	logic [SLOT_W-1:0]             last_inc;
	logic                          issuing;
	logic                          hit_rel;
	logic                          hit_rem;
	logic                          last_match;
	logic [lwt_pkg::TASK_W-1:0]    lm_task;
	logic [lwt_pkg::PID_W-1:0]     lm_pid;
	logic                          enter_free;
	logic                          enter_end;
	logic                          emit_v;
	lwt_pkg::status_t              emit_sts;
	logic                          emit_wake;

	assign accept     = start && !busy;
	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign req        = lwt_pkg::req_t'(req_type);
	assign count_zero = (count_q == '0);
	assign count_full = (count_q == lwt_pkg::COUNT_MAX);
	assign slot_inc   = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
	assign last_inc   = (last_q == SLOT_LAST) ? '0 : last_q + SLOT_W'(1);
	assign issuing    = (pos_q != POS_ALL);

	assign rd_task = ram_rdata[lwt_pkg::ENTRY_W-1:lwt_pkg::PID_W];
	assign rd_pid  = ram_rdata[lwt_pkg::PID_W-1:0];

	// an emptied slot reads as task zero, pid zero
	assign lm_task    = occ_q[last_q] ? rd_task : '0;
	assign lm_pid     = occ_q[last_q] ? rd_pid : '0;
	assign last_match = (lm_task == task_q) && (lm_pid == pid_q);

	assign hit_rel    = (state_q == lwt_pkg::S_RELEASE) && vld_s1 && occ_q[slot_s1];
	assign hit_rem    = (state_q == lwt_pkg::S_REMOVE) && vld_s1 && occ_q[slot_s1]
	                    && (rd_task == task_q);
	assign enter_end  = (pos_q == lim_q);
	assign enter_free = !enter_end && !occ_q[slot_q];

	assign busy = (state_q != lwt_pkg::S_IDLE);

	lwt_ram #(
		.WIDTH (lwt_pkg::ENTRY_W),
		.DEPTH (WAIT_SLOTS),
		.AW    (SLOT_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata ({task_q, pid_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lwt_pkg::S_IDLE: begin
				if (accept) begin
					case (req)
						lwt_pkg::REQ_WAIT: begin
							if (!count_zero) begin
								state_d = (task_id != '0) ? lwt_pkg::S_REMOVE : lwt_pkg::S_IDLE;
							end else if (last_vld_q) begin
								state_d = lwt_pkg::S_LAST_CHK;
							end else begin
								state_d = (task_id != '0) ? lwt_pkg::S_ENTER : lwt_pkg::S_IDLE;
							end
						end
						lwt_pkg::REQ_POST: begin
							if (mode_q) begin
								state_d = count_zero ? lwt_pkg::S_RELEASE : lwt_pkg::S_IDLE;
							end else begin
								state_d = count_full ? lwt_pkg::S_IDLE : lwt_pkg::S_RELEASE;
							end
						end
						default: state_d = lwt_pkg::S_IDLE;
					endcase
				end
			end
			lwt_pkg::S_LAST_CHK: begin
				if (last_match || task_q == '0) begin
					state_d = lwt_pkg::S_IDLE;
				end else begin
					state_d = lwt_pkg::S_ENTER;
				end
			end
			lwt_pkg::S_ENTER: begin
				if (enter_end || !occ_q[slot_q]) begin
					state_d = lwt_pkg::S_IDLE;
				end
			end
			lwt_pkg::S_REMOVE: begin
				if (hit_rem || !issuing) begin
					state_d = lwt_pkg::S_FINISH;
				end
			end
			lwt_pkg::S_RELEASE: begin
				if ((hit_rel && first_q) || !issuing) begin
					state_d = lwt_pkg::S_FINISH;
				end
			end
			lwt_pkg::S_FINISH: state_d = lwt_pkg::S_IDLE;
			default:           state_d = lwt_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer: ram access and result to emit
	always_comb begin
		ram_raddr = slot_q;
		ram_we    = 1'b0;
		emit_v    = 1'b0;
		emit_sts  = lwt_pkg::STS_GRANTED;
		emit_wake = 1'b0;
		case (state_q)
			lwt_pkg::S_IDLE: begin
				// prefetch the last used slot for the duplicate check
				ram_raddr = last_q;
				if (accept) begin
					case (req)
						lwt_pkg::REQ_WAIT: begin
							if (!count_zero && task_id == '0) begin
								emit_v = 1'b1;
							end else if (count_zero && !last_vld_q && task_id == '0) begin
								emit_v   = 1'b1;
								emit_sts = lwt_pkg::STS_FULL;
							end
						end
						lwt_pkg::REQ_TRY: begin
							emit_v   = 1'b1;
							emit_sts = count_zero ? lwt_pkg::STS_WOULD_BLOCK : lwt_pkg::STS_GRANTED;
						end
						lwt_pkg::REQ_POST: begin
							if (mode_q && !count_zero) begin
								emit_v   = 1'b1;
								emit_sts = lwt_pkg::STS_NOT_LOCKED;
							end else if (!mode_q && count_full) begin
								emit_v   = 1'b1;
								emit_sts = lwt_pkg::STS_OVERFLOW;
							end
						end
						default: emit_v = 1'b0;
					endcase
				end
			end
			lwt_pkg::S_LAST_CHK: begin
				if (last_match) begin
					emit_v   = 1'b1;
					emit_sts = lwt_pkg::STS_QUEUED;
				end else if (task_q == '0) begin
					emit_v   = 1'b1;
					emit_sts = lwt_pkg::STS_FULL;
				end
			end
			lwt_pkg::S_ENTER: begin
				if (enter_end) begin
					emit_v   = 1'b1;
					emit_sts = lwt_pkg::STS_FULL;
				end else if (enter_free) begin
					ram_we   = 1'b1;
					emit_v   = 1'b1;
					emit_sts = lwt_pkg::STS_QUEUED;
				end
			end
			lwt_pkg::S_RELEASE: begin
				if (hit_rel) begin
					emit_v    = 1'b1;
					emit_sts  = lwt_pkg::STS_WAKE;
					emit_wake = 1'b1;
				end
			end
			lwt_pkg::S_FINISH: begin
				emit_v = 1'b1;
			end
			default: emit_v = 1'b0;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			task_q <= task_id;
			pid_q  <= task_pid;
		end
		slot_s1  <= slot_q;
		status_q <= emit_sts;
		wtask_q  <= emit_wake ? rd_task : '0;
		wpid_q   <= emit_wake ? rd_pid : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lwt_pkg::S_IDLE;
			mode_q     <= 1'b0;
			init_q     <= '0;
			count_q    <= '0;
			occ_q      <= '0;
			last_q     <= '0;
			last_vld_q <= 1'b0;
			first_q    <= 1'b0;
			slot_q     <= '0;
			pos_q      <= '0;
			lim_q      <= '0;
			vld_s1     <= 1'b0;
			res_vld_q  <= 1'b0;
			last_res_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			res_vld_q  <= emit_v;
			last_res_q <= !emit_wake;
			vld_s1     <= 1'b0;

			if (cfg_we) begin
				// any config write starts the lock over with an empty table
				occ_q      <= '0;
				last_q     <= '0;
				last_vld_q <= 1'b0;
				if (cfg_index == lwt_pkg::CFG_MODE) begin
					mode_q  <= cfg_data[0];
					count_q <= cfg_data[0] ? lwt_pkg::COUNT_W'(1) : init_q;
				end else begin
					init_q  <= cfg_data;
					count_q <= mode_q ? lwt_pkg::COUNT_W'(1) : cfg_data;
				end
			end else begin
				case (state_q)
					lwt_pkg::S_IDLE: begin
						if (accept) begin
							first_q <= mode_q;
							pos_q   <= '0;
							lim_q   <= last_vld_q ? POS_LESS : POS_ALL;
							if (req == lwt_pkg::REQ_WAIT && !count_zero) begin
								slot_q <= '0;
							end else begin
								slot_q <= last_vld_q ? last_inc : '0;
							end
							case (req)
								lwt_pkg::REQ_WAIT, lwt_pkg::REQ_TRY: begin
									if (!count_zero) begin
										count_q <= count_q - lwt_pkg::COUNT_W'(1);
									end
								end
								lwt_pkg::REQ_POST: begin
									if (mode_q) begin
										if (count_zero) begin
											count_q <= lwt_pkg::COUNT_W'(1);
										end
									end else if (!count_full) begin
										count_q <= count_q + lwt_pkg::COUNT_W'(1);
									end
								end
								default: count_q <= count_q;
							endcase
						end
					end
					lwt_pkg::S_ENTER: begin
						if (enter_free) begin
							occ_q[slot_q] <= 1'b1;
							last_q        <= slot_q;
							last_vld_q    <= 1'b1;
						end else if (!enter_end) begin
							slot_q <= slot_inc;
							pos_q  <= pos_q + POS_W'(1);
						end
					end
					lwt_pkg::S_REMOVE, lwt_pkg::S_RELEASE: begin
						// one slot read issued per cycle unless a config write is taken, checked when its registered data returns
						if (issuing) begin
							slot_q <= slot_inc;
							pos_q  <= pos_q + POS_W'(1);
							vld_s1 <= 1'b1;
						end
						if (hit_rem || hit_rel) begin
							occ_q[slot_s1] <= 1'b0;
						end
						if (hit_rem || (hit_rel && first_q)) begin
							vld_s1 <= 1'b0;
						end
					end
					default: count_q <= count_q;
				endcase
			end
		end
	end

	assign result_valid = res_vld_q;
	assign status       = status_q;
	assign wake_task    = wtask_q;
	assign wake_pid     = wpid_q;
	assign last_result  = last_res_q;

endmodule
